// File: design/kls_pkg.sv
package kls_pkg;

  localparam int MAX_RANK    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int RANK_W      = 7;
  localparam int IDX_W       = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

  // control states
  localparam logic ST_RUN     = 1'b0;
  localparam logic ST_EXTRACT = 1'b1;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;    // insert the broadcast key in place
    logic shift;  // move every entry one place toward the head
    logic clear;  // drop all entries
  } cell_ctl_t;

  typedef logic [VALUE_WIDTH-1:0] key_t;

  // order key: sign flipped so unsigned compare matches signed order
  function automatic key_t to_key(input logic [VALUE_WIDTH-1:0] v);
    return {~v[VALUE_WIDTH-1], v[VALUE_WIDTH-2:0]};
  endfunction

endpackage

// File: design/kls_cell.sv
module kls_cell (
  input  logic               clk,
  input  logic               rst,
  input  kls_pkg::cell_ctl_t ctl,
  input  kls_pkg::key_t      key_in,
  input  kls_pkg::key_t      prev_key,
  input  logic               prev_vld,
  input  logic               prev_gt,
  input  kls_pkg::key_t      next_key,
  input  logic               next_vld,
  output kls_pkg::key_t      key,
  output logic               vld,
  output logic               gt
);

  // new key belongs at or above this entry
  assign gt = !vld || (key_in > key);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctl.clear) begin
      vld <= 1'b0;
    end else if (ctl.shift) begin
      vld <= next_vld;
    end else if (ctl.ins && gt) begin
      vld <= prev_gt ? prev_vld : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      key <= next_key;
    end else if (ctl.ins && gt) begin
      key <= prev_gt ? prev_key : key_in;
    end
  end

endmodule

// File: design/kth_largest_selector.sv
// Result: after the transfer marked last, the chain shifts toward its head
//   until the k-th entry sits in cell 0 (no shift when rank_k is 0 or above
//   the list depth); the head is then registered once the output register is free.
// Throughput: one value per cycle inside a set; after the last value the
//   input stalls while the chain shifts and until the result is registered.
// Reset: synchronous; all cell valid bits clear at once, rank_k returns to 1.
module kth_largest_selector (
  input  logic                         clk,
  input  logic                         rst,
  // configuration: rank_k
  input  logic                         cfg_we,
  input  logic [kls_pkg::RANK_W-1:0]   cfg_wdata,
  // input stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [31:0]                  s_tdata,   // [31:0] value
  input  logic                         s_tlast,   // last
  // result stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [31:0]                  m_tdata,   // [31:0] kth_value
  output logic                         m_tuser    // [0] found
);

  localparam int N = kls_pkg::MAX_RANK;
  localparam int W = kls_pkg::VALUE_WIDTH;

  logic [kls_pkg::RANK_W-1:0] rank_k;
  logic                       state;
  logic [kls_pkg::IDX_W-1:0]  cnt;

  kls_pkg::cell_ctl_t ctl;
  kls_pkg::key_t      key_in;
  kls_pkg::key_t      cell_key [N];
  logic [N-1:0]       cell_vld;
  logic [N-1:0]       cell_gt;

  logic in_xfer;
  logic rank_ok;
  logic finish;

  assign s_tready = (state == kls_pkg::ST_RUN);
  assign in_xfer  = s_tvalid && s_tready;
  assign key_in   = kls_pkg::to_key(s_tdata[W-1:0]);
  assign rank_ok  = (rank_k != '0) && (32'(rank_k) <= N);

  // extraction ends once the shift counter reaches zero and the output slot is free
  assign finish = (state == kls_pkg::ST_EXTRACT) && (cnt == '0) &&
                  (!m_tvalid || m_tready);

  assign ctl.ins   = in_xfer;
  assign ctl.shift = (state == kls_pkg::ST_EXTRACT) && (cnt != '0);
  assign ctl.clear = finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_k <= kls_pkg::RANK_W'(1);
    end else if (cfg_we) begin
      rank_k <= cfg_wdata;
    end
  end

  // Sorted list: cell 0 holds the largest key. Insertion uses each cell's
  // compare plus its upper neighbor's; extraction shifts toward cell 0.
  for (genvar i = 0; i < N; i++) begin : g_cell
    kls_pkg::key_t pk, nk;
    logic          pv, pg, nv;
    if (i == 0) begin : g_head
      assign pk = '0;
      assign pv = 1'b0;
      assign pg = 1'b0;
    end else begin : g_mid
      assign pk = cell_key[i-1];
      assign pv = cell_vld[i-1];
      assign pg = cell_gt[i-1];
    end
    if (i == N-1) begin : g_tail
      assign nk = '0;
      assign nv = 1'b0;
    end else begin : g_body
      assign nk = cell_key[i+1];
      assign nv = cell_vld[i+1];
    end
    kls_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .key_in   (key_in),
      .prev_key (pk),
      .prev_vld (pv),
      .prev_gt  (pg),
      .next_key (nk),
      .next_vld (nv),
      .key      (cell_key[i]),
      .vld      (cell_vld[i]),
      .gt       (cell_gt[i])
    );
  end

  // control: run -> extract on the last transfer, back once the result
  // is captured
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kls_pkg::ST_RUN;
      cnt   <= '0;
    end else if (state == kls_pkg::ST_RUN) begin
      if (in_xfer && s_tlast) begin
        state <= kls_pkg::ST_EXTRACT;
        cnt   <= rank_ok ? kls_pkg::IDX_W'(rank_k - kls_pkg::RANK_W'(1)) : '0;
      end
    end else begin
      if (ctl.shift) begin
        cnt <= cnt - kls_pkg::IDX_W'(1);
      end
      if (finish) begin
        state <= kls_pkg::ST_RUN;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tuser <= rank_ok && cell_vld[0];
      m_tdata <= (rank_ok && cell_vld[0]) ? 32'(kls_pkg::to_key(cell_key[0])) : '0;
    end
  end

`ifndef SYNTHESIS
  // the last value of a set always starts extraction
  a_last_extract: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> (state == kls_pkg::ST_EXTRACT))
    else $error("last transfer did not start extraction");

  // valid entries form a contiguous run from the head of the chain
  a_vld_prefix: assert property (@(posedge clk) disable iff (rst)
    ((cell_vld & (cell_vld + N'(1))) == '0))
    else $error("valid entries not contiguous from head");

  // the list is empty once a result has been captured
  a_clear: assert property (@(posedge clk) disable iff (rst)
    finish |=> (cell_vld == '0))
    else $error("list not cleared after result");
`endif

endmodule

// File: verif/kls_checker.sv
module kls_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [kls_pkg::RANK_W-1:0] cfg_wdata,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [31:0]                s_tdata,   // [31:0] value
  input  logic                       s_tlast,   // last
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [31:0]                m_tdata,   // [31:0] kth_value
  input  logic                       m_tuser,   // [0] found
  output int                         fail_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] kth_value;
    logic               found;
  } kth_result_t;

  // descending list of the largest values of the open set
  logic signed [31:0]          top_values [kls_pkg::MAX_RANK];
  int                          top_count;
  logic [kls_pkg::RANK_W-1:0]  rank_sel;
  kth_result_t                 kth_pending [$];
  kth_result_t                 want;
  int                          mismatches;

  task automatic rank_insert(input logic signed [31:0] v);
    int pos;
    int last_i;
    pos = 0;
    while (pos < top_count && top_values[pos] >= v) pos++;
    if (pos < kls_pkg::MAX_RANK) begin
      last_i = (top_count < kls_pkg::MAX_RANK) ? top_count : kls_pkg::MAX_RANK - 1;
      for (int i = last_i; i > pos; i--) top_values[i] = top_values[i-1];
      top_values[pos] = v;
      if (top_count < kls_pkg::MAX_RANK) top_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      top_count = 0;
      rank_sel  = kls_pkg::RANK_W'(1);
      kth_pending.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (kth_pending.size() == 0) begin
          $display("%0t unexpected result: expected none, got kth_value %0d found %0b",
                   $time, $signed(m_tdata), m_tuser);
          mismatches++;
        end else begin
          want = kth_pending.pop_front();
          if ($signed(m_tdata) !== want.kth_value) begin
            $display("%0t kth_value mismatch: expected %0d, got %0d",
                     $time, want.kth_value, $signed(m_tdata));
            mismatches++;
          end
          if (m_tuser !== want.found) begin
            $display("%0t found mismatch: expected %0b, got %0b",
                     $time, want.found, m_tuser);
            mismatches++;
          end
        end
      end
      if (cfg_we) rank_sel = cfg_wdata;
      if (s_tvalid && s_tready) begin
        rank_insert($signed(s_tdata));
        if (s_tlast) begin
          want.kth_value = 0;
          want.found     = 1'b0;
          if (rank_sel >= 1 && rank_sel <= kls_pkg::MAX_RANK && rank_sel <= top_count) begin
            want.kth_value = top_values[rank_sel - 1];
            want.found     = 1'b1;
          end
          top_count = 0;
          kth_pending.insert(kth_pending.size(), want);
        end
      end
    end
    fail_count <= mismatches;
    pending    <= kth_pending.size();
  end

endmodule

// File: verif/kth_largest_selector_tb.sv
module kth_largest_selector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ITEM_TARGET = 750;
  localparam int          CYCLE_LIMIT = 400000;  // far above the slowest legal run
  localparam int          DRAIN       = 80;      // extra wait after all results are back
  localparam logic [31:0] VAL_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_MIN     = 32'h8000_0000;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [kls_pkg::RANK_W-1:0] cfg_wdata = '0;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [31:0]                s_tdata = '0;     // [31:0] value
  logic                       s_tlast = 1'b0;   // last
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [31:0]                m_tdata;          // [31:0] kth_value
  logic                       m_tuser;          // [0] found

  int                  fail_count;
  int                  pending;
  int                  items_sent = 0;
  int                  cycle_count = 0;
  logic                steady = 1'b0;    // both sides run with no idle cycles

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  kth_largest_selector uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  kls_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Offer one value; returns right after the edge that completes the transfer.
  // With a zero gap tvalid simply stays high into the next item.
  task automatic offer_value(input logic [31:0] v, input logic last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Sender pause: nothing is offered until every result is back.
  // The first edge lets the checker count a last that transferred just now.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // rank_k only changes while the block is idle between sets
  task automatic write_rank(input logic [kls_pkg::RANK_W-1:0] r);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mix of full-range values, extremes and a narrow band that breeds duplicates
  function automatic logic [31:0] pick_value();
    logic [31:0] narrow;
    narrow = $urandom_range(0, 16);
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2, 3, 4: return narrow - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  // Set lengths cluster around the rank so short and just-long-enough sets
  // both occur; a few long sets overflow the list and drop its tail.
  function automatic int pick_length(input logic [kls_pkg::RANK_W-1:0] r);
    if (r >= 1 && r <= kls_pkg::MAX_RANK) begin
      case ($urandom_range(0, 15))
        0:                return $urandom_range(kls_pkg::MAX_RANK - 4, kls_pkg::MAX_RANK + 26);
        1, 2, 3, 4, 5, 6: return $urandom_range(1, r + 2);
        default:          return $urandom_range(1, 12);
      endcase
    end
    return $urandom_range(1, 10);
  endfunction

  task automatic send_set(input int len);
    for (int i = 0; i < len; i++) offer_value(pick_value(), i == len - 1);
  endtask

  function automatic logic [kls_pkg::RANK_W-1:0] pick_rank(input int phase);
    case (phase)
      0: return 7'd64;
      1: return 7'd127;
      2: return 7'd0;
      3: return 7'd65;
      4: return 7'd1;
      5: return 7'd63;
      default: ;
    endcase
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
        return kls_pkg::RANK_W'($urandom_range(1, 8));
      10, 11, 12, 13, 14, 15, 16:
        return kls_pkg::RANK_W'($urandom_range(1, kls_pkg::MAX_RANK));
      17:
        return 7'd0;
      18:
        return 7'd64;
      default:
        return kls_pkg::RANK_W'($urandom_range(kls_pkg::MAX_RANK + 1, 127));
    endcase
  endfunction

  // Receiver: random hold-offs per result, none while steady, and two long
  // hold-offs that back the block up until its input stalls. The first one
  // covers the opening directed sets, which follow each other with no pause.
  initial begin
    int gap;
    int taken;
    taken = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (taken == 0 || taken == 120) gap = 300;
      else if (steady) gap = 0;
      else gap = $urandom_range(0, 9);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int phase;
    int sets;
    logic [kls_pkg::RANK_W-1:0] r;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: rank_k is 1 out of reset, so these report the maximum
    offer_value(VAL_MAX, 1'b1);
    offer_value(VAL_MIN, 1'b1);
    offer_value(32'hFFFF_FFFF, 1'b0);
    offer_value(32'd0, 1'b0);
    offer_value(32'd5, 1'b0);
    offer_value(32'd5, 1'b1);
    // duplicates count as separate ranks; a single value cannot have rank 2
    write_rank(7'd2);
    offer_value(32'd5, 1'b0);
    offer_value(32'd5, 1'b1);
    offer_value(32'd7, 1'b1);
    // smallest possible value at rank 3 is still found
    write_rank(7'd3);
    offer_value(VAL_MIN, 1'b0);
    offer_value(VAL_MAX, 1'b0);
    offer_value(VAL_MIN, 1'b1);
    // rank zero and ranks beyond the list depth never find anything
    write_rank(7'd0);
    offer_value(32'd3, 1'b1);
    write_rank(7'd65);
    offer_value(32'd1, 1'b0);
    offer_value(32'd2, 1'b1);
    write_rank(7'd127);
    offer_value(32'd9, 1'b1);

    // Random phases: each writes a rank, then streams several whole sets
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      r = pick_rank(phase);
      write_rank(r);
      steady = ($urandom_range(0, 3) == 0);
      sets = $urandom_range(2, 8);
      for (int s = 0; s < sets && items_sent < ITEM_TARGET; s++) send_set(pick_length(r));
      phase++;
    end
    steady = 1'b0;

    drain_results();
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: kth_largest_selector.f
design/kls_pkg.sv
design/kls_cell.sv
design/kth_largest_selector.sv
verif/kls_checker.sv
verif/kth_largest_selector_tb.sv
